>>> hw/rtl/assert_macros.svh
// assertion macros shared by the i2c master bit sequencer rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hw/rtl/i2cms_pkg.sv
// shared types and constants of the i2c master bit sequencer
// no dependencies; used by i2cms_ctrl, i2cms_dpath and the top level
package i2cms_pkg;

  // request widths on the streaming ports
  localparam int CMD_W   = 2;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 16;
  localparam int PHASE_W = 5;

  // bus commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  // sda source select
  typedef logic [2:0] sda_sel_t;
  localparam sda_sel_t SDA_KEEP = 3'd0;
  localparam sda_sel_t SDA_LOW  = 3'd1;
  localparam sda_sel_t SDA_HIGH = 3'd2;
  localparam sda_sel_t SDA_TX   = 3'd3;
  localparam sda_sel_t SDA_NACK = 3'd4;

  // phase counts and loop bounds
  localparam logic [PHASE_W-1:0] WR_BIT_PHASES = 5'd24;
  localparam logic [PHASE_W-1:0] RD_BIT_PHASES = 5'd16;
  localparam logic [PHASE_W-1:0] MAX_PHASES    = 5'd27;

  // controller to datapath command
  typedef struct packed {
    logic     load;      // latch a new request
    logic     step;      // emit one phase
    logic     set_scl;
    logic     scl_val;
    sda_sel_t sda_sel;
    logic     sample;    // sda sampled in this phase
    logic     wr_ack;    // sample is the write acknowledge
    logic     last;
    logic     show_rx;
    logic     show_ack;
  } op_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;     // output register can take a phase
  } status_t;

endpackage

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
// i2c master bit sequencer: one request per bus command, one result per line phase
// after a request is taken the controller runs, and loads the first phase into the output
// register when it is free; a new request is taken only after the last phase of the one before,
// and the controller's phase counter emits one phase per cycle while the output slot is free
// reset: synchronous active-high rst releases both lines high and empties the output register
// depends on i2cms_pkg, i2cms_ctrl, i2cms_dpath
module i2c_master_bit_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // data_byte[7:0], send_nack[8], line_samples[16:9], ack_level[17], zero pad
  input  logic [i2cms_pkg::S_DATA_W-1:0] s_tdata,
  // command[1:0]
  input  logic [i2cms_pkg::CMD_W-1:0]    s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // scl_level[0], sda_level[1], received_byte[9:2], ack_seen[10], zero pad
  output logic [i2cms_pkg::M_DATA_W-1:0] m_tdata,
  // sample_point[0]
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import i2cms_pkg::*;

  op_t     op;
  status_t status;

  // request fsm and phase decode
  i2cms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .op       (op)
  );

  // line state and result register
  i2cms_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .op       (op),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );
endmodule

>>> hw/rtl/i2cms_ctrl.sv
// controller of the i2c master bit sequencer: request fsm and phase decode
// depends on i2cms_pkg and assert_macros.svh
`include "assert_macros.svh"
module i2cms_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [i2cms_pkg::CMD_W-1:0] s_tuser,
  input  i2cms_pkg::status_t          status,
  output i2cms_pkg::op_t              op
);
  import i2cms_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state;
  logic [CMD_W-1:0]   cmd;
  logic [PHASE_W-1:0] phase;
  logic [1:0]         sub;
  logic [1:0]         sub_wrap;

  assign s_tready = (state == ST_IDLE);
  assign sub_wrap = (cmd == CMD_WRITE) ? 2'd2 : 2'd1;

  // phase decode
  always_comb begin
    op = '0;
    op.sda_sel = SDA_KEEP;
    op.load = s_tvalid && (state == ST_IDLE);
    op.step = (state == ST_RUN) && status.slot_free;
    unique case (cmd)
      CMD_START: begin
        case (phase)
          5'd0: op.sda_sel = SDA_HIGH;
          5'd1: begin op.set_scl = 1'b1; op.scl_val = 1'b1; end
          5'd2: op.sda_sel = SDA_LOW;
          default: begin op.set_scl = 1'b1; op.last = 1'b1; end
        endcase
      end
      CMD_STOP: begin
        case (phase)
          5'd0: op.sda_sel = SDA_LOW;
          5'd1: begin op.set_scl = 1'b1; op.scl_val = 1'b1; end
          default: begin op.sda_sel = SDA_HIGH; op.last = 1'b1; end
        endcase
      end
      CMD_WRITE: begin
        if (phase < WR_BIT_PHASES) begin
          case (sub)
            2'd0: op.sda_sel = SDA_TX;
            2'd1: begin op.set_scl = 1'b1; op.scl_val = 1'b1; end
            default: op.set_scl = 1'b1;
          endcase
        end else begin
          case (phase)
            5'd24: op.sda_sel = SDA_HIGH;
            5'd25: begin
              op.set_scl = 1'b1;
              op.scl_val = 1'b1;
              op.sample  = 1'b1;
              op.wr_ack  = 1'b1;
            end
            default: begin
              op.set_scl  = 1'b1;
              op.last     = 1'b1;
              op.show_ack = 1'b1;
            end
          endcase
        end
      end
      CMD_READ: begin
        if (phase < RD_BIT_PHASES) begin
          op.set_scl = 1'b1;
          if (sub == 2'd0) begin
            op.scl_val = 1'b1;
            op.sample  = 1'b1;
          end
        end else begin
          case (phase)
            5'd16: op.sda_sel = SDA_NACK;
            5'd17: begin op.set_scl = 1'b1; op.scl_val = 1'b1; end
            5'd18: op.set_scl = 1'b1;
            default: begin
              op.sda_sel = SDA_HIGH;
              op.last    = 1'b1;
              op.show_rx = 1'b1;
            end
          endcase
        end
      end
      default: op.last = 1'b1;
    endcase
  end

  // request fsm and phase counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
      sub   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (op.load) begin
            state <= ST_RUN;
            phase <= '0;
            sub   <= '0;
          end
        end
        ST_RUN: begin
          if (op.step) begin
            phase <= phase + 5'd1;
            sub   <= (sub == sub_wrap) ? 2'd0 : sub + 2'd1;
            if (op.last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // command register, no reset needed
  always_ff @(posedge clk) begin
    if (op.load) begin
      cmd <= s_tuser;
    end
  end

  `ASSERT_IMPL(a_phase_bound, clk, rst, state == ST_RUN, phase < MAX_PHASES)
  `ASSERT_NEXT(a_last_to_idle, clk, rst, op.step && op.last, state == ST_IDLE)
  `ASSERT_IMPL(a_step_needs_slot, clk, rst, op.step, status.slot_free)
endmodule

>>> hw/rtl/i2cms_dpath.sv
// datapath of the i2c master bit sequencer: line state, shifters, output register
// depends on i2cms_pkg and assert_macros.svh
`include "assert_macros.svh"
module i2cms_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [i2cms_pkg::S_DATA_W-1:0] s_tdata,
  input  i2cms_pkg::op_t                 op,
  output i2cms_pkg::status_t             status,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [i2cms_pkg::M_DATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import i2cms_pkg::*;

  logic       scl_line;
  logic       sda_line;
  logic       scl_next;
  logic       sda_next;
  logic [7:0] tx_sh;
  logic [7:0] smp_sh;
  logic [7:0] rx_sh;
  logic       nack;
  logic       ack_lvl;
  logic       ack;

  assign status.slot_free = !m_tvalid || m_tready;

  // next line levels
  assign scl_next = op.set_scl ? op.scl_val : scl_line;
  always_comb begin
    unique case (op.sda_sel)
      SDA_LOW:  sda_next = 1'b0;
      SDA_HIGH: sda_next = 1'b1;
      SDA_TX:   sda_next = tx_sh[7];
      SDA_NACK: sda_next = nack;
      default:  sda_next = sda_line;
    endcase
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      scl_line <= 1'b1;
      sda_line <= 1'b1;
    end else if (op.step) begin
      scl_line <= scl_next;
      sda_line <= sda_next;
    end
  end

  // request fields and shifters
  always_ff @(posedge clk) begin
    if (op.load) begin
      tx_sh   <= s_tdata[7:0];
      nack    <= s_tdata[8];
      smp_sh  <= s_tdata[16:9];
      ack_lvl <= s_tdata[17];
      rx_sh   <= '0;
    end else if (op.step) begin
      if (op.sda_sel == SDA_TX) begin
        tx_sh <= {tx_sh[6:0], 1'b0};
      end
      if (op.sample && op.wr_ack) begin
        ack <= ack_lvl & sda_line;
      end else if (op.sample) begin
        rx_sh  <= {rx_sh[6:0], smp_sh[7] & sda_line};
        smp_sh <= {smp_sh[6:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.step) begin
      m_tdata[0]    <= scl_next;
      m_tdata[1]    <= sda_next;
      m_tdata[9:2]  <= op.show_rx ? rx_sh : 8'd0;
      m_tdata[10]   <= op.show_ack ? ack : 1'b0;
      m_tdata[15:11] <= '0;
      m_tuser       <= op.sample;
      m_tlast       <= op.last;
    end
  end

  `ASSERT_IMPL(a_fields_only_last, clk, rst, m_tvalid && !m_tlast, m_tdata[10:2] == 9'd0)
  `ASSERT_IMPL(a_sample_clock_high, clk, rst, m_tvalid && m_tuser, m_tdata[0])
endmodule

>>> test/i2c_master_bit_sequencer_unit_test.sv
// testbench for the i2c master bit sequencer: commands go in, bus phases are predicted and checked
// directed command cases first, then random transactions with idle bursts on both streams
// depends on i2cms_pkg and i2c_master_bit_sequencer_unit
module i2c_master_bit_sequencer_unit_test;
  import i2cms_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_PAD       = 8;
  localparam int RANDOM_REQUESTS = 200;
  localparam int QUIET_TAIL      = 30;

  // one bus phase as seen on the result stream
  typedef struct {
    logic       scl;
    logic       sda;
    logic       sample;
    logic       last;
    logic [7:0] rx_byte;
    logic       ack;
  } bus_phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = CMD_START;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  // line state of the bus model and the phases still owed by the block
  logic       scl_model = 1'b1;
  logic       sda_model = 1'b1;
  bus_phase_t phase_queue[$];

  bit sender_idle   = 1'b0;
  bit receiver_idle = 1'b0;
  int stall_left    = 0;
  int error_count   = 0;
  int phases_checked = 0;
  int requests_sent = 0;
  int cmd_count[4]  = '{0, 0, 0, 0};
  int cycle_count   = 0;

  i2c_master_bit_sequencer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // record the current line state as one expected phase
  task automatic push_phase(input logic sample, input logic last, input logic [7:0] rx_byte,
                            input logic ack);
    bus_phase_t p;
    p.scl     = scl_model;
    p.sda     = sda_model;
    p.sample  = sample;
    p.last    = last;
    p.rx_byte = rx_byte;
    p.ack     = ack;
    phase_queue.push_back(p);
  endtask

  // bus model: expand one command into its phase sequence
  task automatic predict_bus_phases(input logic [CMD_W-1:0] cmd, input logic [7:0] data,
                                    input logic nack, input logic [7:0] samples,
                                    input logic ack_in);
    logic [7:0] rx_byte;
    int         i;
    rx_byte = 8'd0;
    case (cmd)
      CMD_START: begin
        sda_model = 1'b1; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        scl_model = 1'b1; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        sda_model = 1'b0; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        scl_model = 1'b0; push_phase(1'b0, 1'b1, 8'd0, 1'b0);
      end
      CMD_STOP: begin
        sda_model = 1'b0; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        scl_model = 1'b1; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        sda_model = 1'b1; push_phase(1'b0, 1'b1, 8'd0, 1'b0);
      end
      CMD_WRITE: begin
        for (i = 7; i >= 0; i--) begin
          sda_model = data[i]; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
          scl_model = 1'b1;    push_phase(1'b0, 1'b0, 8'd0, 1'b0);
          scl_model = 1'b0;    push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        end
        // sda released before the acknowledge clock
        sda_model = 1'b1; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        scl_model = 1'b1; push_phase(1'b1, 1'b0, 8'd0, 1'b0);
        scl_model = 1'b0; push_phase(1'b0, 1'b1, 8'd0, ack_in & sda_model);
      end
      CMD_READ: begin
        // wired-and: a master still holding sda low reads zeros
        for (i = 7; i >= 0; i--) begin
          scl_model  = 1'b1;
          rx_byte[i] = samples[i] & sda_model;
          push_phase(1'b1, 1'b0, 8'd0, 1'b0);
          scl_model = 1'b0; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        end
        sda_model = nack; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        scl_model = 1'b1; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        scl_model = 1'b0; push_phase(1'b0, 1'b0, 8'd0, 1'b0);
        sda_model = 1'b1; push_phase(1'b0, 1'b1, rx_byte, 1'b0);
      end
    endcase
  endtask

  // send one command request, with an optional idle burst ahead of it
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [7:0] data,
                              input logic nack, input logic [7:0] samples,
                              input logic ack_in);
    int gap;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, ack_in, samples, nack, data};
    do @(posedge clk); while (!s_tready);
    predict_bus_phases(cmd, data, nack, samples, ack_in);
    requests_sent++;
    cmd_count[cmd]++;
  endtask

  task automatic send_random(input logic [CMD_W-1:0] cmd);
    send_command(cmd, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // hold the sender until every owed phase has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (phase_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at phase %0d: %s got %0h expected %0h", phases_checked, what, got,
             want);
    error_count++;
  endtask

  // result checker and receiver stall bursts
  always @(posedge clk) begin : check_phases
    bus_phase_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (phase_queue.size() == 0) begin
        report_mismatch("phase with none owed, scl/sda", int'(m_tdata[1:0]), 0);
      end else begin
        want = phase_queue.pop_front();
        if (m_tdata[0] !== want.scl)
          report_mismatch("scl_level", int'(m_tdata[0]), int'(want.scl));
        if (m_tdata[1] !== want.sda)
          report_mismatch("sda_level", int'(m_tdata[1]), int'(want.sda));
        if (m_tuser !== want.sample)
          report_mismatch("sample_point", int'(m_tuser), int'(want.sample));
        if (m_tlast !== want.last)
          report_mismatch("last_phase", int'(m_tlast), int'(want.last));
        if (m_tdata[9:2] !== want.rx_byte)
          report_mismatch("received_byte", int'(m_tdata[9:2]), int'(want.rx_byte));
        if (m_tdata[10] !== want.ack)
          report_mismatch("ack_seen", int'(m_tdata[10]), int'(want.ack));
      end
      phases_checked++;
    end
    if (receiver_idle && stall_left == 0 && $urandom_range(0, 3) == 0)
      stall_left = $urandom_range(1, 4);
    m_tready <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d phases still owed", phase_queue.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_start_stop();
    send_command(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(CMD_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1);
    wait_drained();
  endtask

  // data extremes and both acknowledge levels
  task automatic test_write_bytes();
    send_command(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(CMD_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_command(CMD_WRITE, 8'h80, 1'b0, 8'h5A, 1'b0);
    send_command(CMD_WRITE, 8'h01, 1'b1, 8'hA5, 1'b1);
    send_command(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
  endtask

  // first read straight after start sees sda held low by the master
  task automatic test_read_bytes();
    send_command(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(CMD_READ, 8'h00, 1'b0, 8'hFF, 1'b1);
    send_command(CMD_READ, 8'hFF, 1'b0, 8'hFF, 1'b0);
    send_command(CMD_READ, 8'h00, 1'b1, 8'h00, 1'b1);
    send_command(CMD_READ, 8'h3C, 1'b0, 8'hA5, 1'b0);
    send_command(CMD_READ, 8'hC3, 1'b1, 8'h5A, 1'b1);
    send_command(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    wait_drained();
  endtask

  // commands in orders a real bus would not use
  task automatic test_command_order();
    send_command(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(CMD_WRITE, 8'h3C, 1'b0, 8'h00, 1'b1);
    send_command(CMD_READ, 8'h00, 1'b1, 8'hC3, 1'b0);
    send_command(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(CMD_READ, 8'h00, 1'b1, 8'hFF, 1'b0);
    send_command(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
  endtask

  // start, a few data bytes with an occasional repeated start, stop
  task automatic run_transaction();
    int n;
    int k;
    n = $urandom_range(1, 4);
    send_random(CMD_START);
    for (k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 5) == 0) send_random(CMD_START);
      send_random($urandom_range(0, 1) ? CMD_READ : CMD_WRITE);
    end
    send_random(CMD_STOP);
  endtask

  task automatic test_random_traffic();
    int target;
    target = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < target) begin
      if (target - requests_sent < QUIET_TAIL) begin
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        sender_idle   = $urandom_range(0, 1);
        receiver_idle = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 4) == 0) send_random(2'($urandom));
      else run_transaction();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    test_start_stop();
    test_write_bytes();
    test_read_bytes();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    test_command_order();
    wait_drained();
    test_random_traffic();
    $display("sent %0d commands: %0d start, %0d stop, %0d write, %0d read", requests_sent,
             cmd_count[CMD_START], cmd_count[CMD_STOP], cmd_count[CMD_WRITE],
             cmd_count[CMD_READ]);
    $display("checked %0d bus phases, %0d mismatches", phases_checked, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
